// ===== hw/rtl/talu_pkg.sv =====
package talu_pkg;

    // data path width
    localparam int unsigned WordW = 32;
    localparam int unsigned OpW   = 4;
    localparam int unsigned AmtW  = 8;
    localparam int unsigned ShW   = $clog2(WordW);

    // operation codes
    localparam logic [OpW-1:0] OP_AND = 4'd0;
    localparam logic [OpW-1:0] OP_EOR = 4'd1;
    localparam logic [OpW-1:0] OP_LSL = 4'd2;
    localparam logic [OpW-1:0] OP_LSR = 4'd3;
    localparam logic [OpW-1:0] OP_ASR = 4'd4;
    localparam logic [OpW-1:0] OP_ADC = 4'd5;
    localparam logic [OpW-1:0] OP_SBC = 4'd6;
    localparam logic [OpW-1:0] OP_ROR = 4'd7;
    localparam logic [OpW-1:0] OP_TST = 4'd8;
    localparam logic [OpW-1:0] OP_NEG = 4'd9;
    localparam logic [OpW-1:0] OP_CMP = 4'd10;
    localparam logic [OpW-1:0] OP_CMN = 4'd11;
    localparam logic [OpW-1:0] OP_ORR = 4'd12;
    localparam logic [OpW-1:0] OP_MUL = 4'd13;
    localparam logic [OpW-1:0] OP_BIC = 4'd14;
    localparam logic [OpW-1:0] OP_MVN = 4'd15;

    // shift kinds handed to the shifter
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

    typedef struct packed {
        logic [WordW-1:0] value;
        logic             carry;
    } shift_res_t;

endpackage

// ===== hw/rtl/thumb_alu_operation_unit_core.sv =====
// Thumb register ALU (format 4): AND, EOR, LSL, LSR, ASR, ADC, SBC, ROR, TST, NEG, CMP,
// CMN, ORR, MUL, BIC and MVN on two 32-bit registers with N, Z, C, V update. A word is
// taken into an input register, computed in one combinational pass (shifter, adder and
// a 32x32 multiplier keeping the low word) and captured in the result register, so
// out_valid rises once the word has passed the input and result registers, and one
// word is accepted every cycle while out_stall is low. The multiplier path sets the
// clock limit.
module thumb_alu_operation_unit_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [talu_pkg::OpW-1:0]   alu_op,
    input  logic [talu_pkg::WordW-1:0] dest_value,
    input  logic [talu_pkg::WordW-1:0] source_value,
    input  logic                       flag_n_in,
    input  logic                       flag_z_in,
    input  logic                       flag_c_in,
    input  logic                       flag_v_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [talu_pkg::WordW-1:0] result_value,
    output logic                       write_back,
    output logic                       flag_n_out,
    output logic                       flag_z_out,
    output logic                       flag_c_out,
    output logic                       flag_v_out
);

    localparam int unsigned W = talu_pkg::WordW;

    logic                       in_valid_reg;
    logic                       in_valid_next;
    logic [talu_pkg::OpW-1:0]   op_reg;
    logic [W-1:0]               a_reg;
    logic [W-1:0]               b_reg;
    talu_pkg::flags_t           flags_reg;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [W-1:0]               result_reg;
    logic                       wb_reg;
    talu_pkg::flags_t           flags_out_reg;
    logic                       advance;
    logic                       accept;
    logic [W-1:0]               exec_result;
    logic                       exec_wb;
    talu_pkg::flags_t           exec_flags;

    // pipeline control
    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input word register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= alu_op;
            a_reg       <= dest_value;
            b_reg       <= source_value;
            flags_reg.n <= flag_n_in;
            flags_reg.z <= flag_z_in;
            flags_reg.c <= flag_c_in;
            flags_reg.v <= flag_v_in;
        end
    end

    talu_exec u_exec (
        .op        (op_reg),
        .a         (a_reg),
        .b         (b_reg),
        .flags_in  (flags_reg),
        .result    (exec_result),
        .wb        (exec_wb),
        .flags_out (exec_flags)
    );

    // result word register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg    <= exec_result;
            wb_reg        <= exec_wb;
            flags_out_reg <= exec_flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign write_back   = wb_reg;
    assign flag_n_out   = flags_out_reg.n;
    assign flag_z_out   = flags_out_reg.z;
    assign flag_c_out   = flags_out_reg.c;
    assign flag_v_out   = flags_out_reg.v;

endmodule

// ===== hw/rtl/talu_shifter.sv =====
module talu_shifter (
    input  logic [1:0]                 kind,
    input  logic [talu_pkg::WordW-1:0] value,
    input  logic [talu_pkg::AmtW-1:0]  amount,
    input  logic                       carry_in,
    output talu_pkg::shift_res_t       res
);

    localparam int unsigned W  = talu_pkg::WordW;
    localparam int unsigned SW = talu_pkg::ShW;

    logic [SW-1:0]  low;
    logic           is_zero;
    logic           is_word;
    logic           is_over;
    logic [W:0]     lsl_wide;
    logic [W:0]     lsr_wide;
    logic [W:0]     asr_wide;
    logic [2*W-1:0] ror_wide;

    // amount decode
    assign low     = amount[SW-1:0];
    assign is_zero = (amount == '0);
    assign is_word = (amount == talu_pkg::AmtW'(W));
    assign is_over = (amount > talu_pkg::AmtW'(W));

    // barrel shifts with the carry bit carried along
    assign lsl_wide = {1'b0, value} << low;
    assign lsr_wide = {value, 1'b0} >> low;
    assign asr_wide = (W+1)'($signed({value, 1'b0}) >>> low);
    assign ror_wide = {value, value} >> low;

    always_comb
    begin
        res.value = value;
        res.carry = carry_in;
        case (kind)
            talu_pkg::SH_LSL:
            begin
                if (is_zero)
                begin
                    res.value = value;
                end
                else if (is_word)
                begin
                    res.value = '0;
                    res.carry = value[0];
                end
                else if (is_over)
                begin
                    res.value = '0;
                    res.carry = 1'b0;
                end
                else
                begin
                    res.value = lsl_wide[W-1:0];
                    res.carry = lsl_wide[W];
                end
            end
            talu_pkg::SH_LSR:
            begin
                if (is_zero)
                begin
                    res.value = value;
                end
                else if (is_word)
                begin
                    res.value = '0;
                    res.carry = value[W-1];
                end
                else if (is_over)
                begin
                    res.value = '0;
                    res.carry = 1'b0;
                end
                else
                begin
                    res.value = lsr_wide[W:1];
                    res.carry = lsr_wide[0];
                end
            end
            talu_pkg::SH_ASR:
            begin
                if (is_zero)
                begin
                    res.value = value;
                end
                else if (is_word || is_over)
                begin
                    res.value = {W{value[W-1]}};
                    res.carry = value[W-1];
                end
                else
                begin
                    res.value = asr_wide[W:1];
                    res.carry = asr_wide[0];
                end
            end
            default:
            begin
                // rotate: the last bit rotated out lands in bit 31
                if (!is_zero)
                begin
                    res.value = ror_wide[W-1:0];
                    res.carry = ror_wide[W-1];
                end
            end
        endcase
    end

endmodule

// ===== hw/rtl/talu_exec.sv =====
module talu_exec (
    input  logic [talu_pkg::OpW-1:0]   op,
    input  logic [talu_pkg::WordW-1:0] a,
    input  logic [talu_pkg::WordW-1:0] b,
    input  talu_pkg::flags_t           flags_in,
    output logic [talu_pkg::WordW-1:0] result,
    output logic                       wb,
    output talu_pkg::flags_t           flags_out
);

    localparam int unsigned W = talu_pkg::WordW;

    logic [1:0]           sh_kind;
    talu_pkg::shift_res_t sh_res;
    logic [W-1:0]         add_x;
    logic [W-1:0]         add_y;
    logic                 add_cin;
    logic [W:0]           add_sum;
    logic                 add_v;
    logic [W-1:0]         product;
    logic                 c_next;
    logic                 v_next;

    // shift kind decoded from the operation code
    always_comb
    begin
        unique case (op)
            talu_pkg::OP_LSL: sh_kind = talu_pkg::SH_LSL;
            talu_pkg::OP_LSR: sh_kind = talu_pkg::SH_LSR;
            talu_pkg::OP_ASR: sh_kind = talu_pkg::SH_ASR;
            default:          sh_kind = talu_pkg::SH_ROR;
        endcase
    end

    talu_shifter u_shifter (
        .kind     (sh_kind),
        .value    (a),
        .amount   (b[talu_pkg::AmtW-1:0]),
        .carry_in (flags_in.c),
        .res      (sh_res)
    );

    // adder operand select
    always_comb
    begin
        add_x   = a;
        add_y   = b;
        add_cin = 1'b0;
        unique case (op)
            talu_pkg::OP_ADC:
            begin
                add_cin = flags_in.c;
            end
            talu_pkg::OP_SBC:
            begin
                add_y   = ~b;
                add_cin = flags_in.c;
            end
            talu_pkg::OP_NEG:
            begin
                add_x   = '0;
                add_y   = ~b;
                add_cin = 1'b1;
            end
            talu_pkg::OP_CMP:
            begin
                add_y   = ~b;
                add_cin = 1'b1;
            end
            default:
            begin
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, add_x} + {1'b0, add_y} + (W+1)'(add_cin);
    assign add_v   = ~(add_x[W-1] ^ add_y[W-1]) & (add_x[W-1] ^ add_sum[W-1]);

    // low word of the product is all that is kept
    assign product = a * b;

    // result and flag select
    always_comb
    begin
        result = '0;
        wb     = 1'b1;
        c_next = flags_in.c;
        v_next = flags_in.v;
        unique case (op) inside
            talu_pkg::OP_AND: result = a & b;
            talu_pkg::OP_EOR: result = a ^ b;
            talu_pkg::OP_LSL, talu_pkg::OP_LSR, talu_pkg::OP_ASR, talu_pkg::OP_ROR:
            begin
                result = sh_res.value;
                c_next = sh_res.carry;
            end
            talu_pkg::OP_ADC, talu_pkg::OP_SBC, talu_pkg::OP_NEG:
            begin
                result = add_sum[W-1:0];
                c_next = add_sum[W];
                v_next = add_v;
            end
            talu_pkg::OP_CMP, talu_pkg::OP_CMN:
            begin
                result = add_sum[W-1:0];
                c_next = add_sum[W];
                v_next = add_v;
                wb     = 1'b0;
            end
            talu_pkg::OP_TST:
            begin
                result = a & b;
                wb     = 1'b0;
            end
            talu_pkg::OP_ORR: result = a | b;
            talu_pkg::OP_MUL: result = product;
            talu_pkg::OP_BIC: result = a & ~b;
            default:          result = ~b;
        endcase
    end

    assign flags_out.n = result[W-1];
    assign flags_out.z = (result == '0);
    assign flags_out.c = c_next;
    assign flags_out.v = v_next;

endmodule

// ===== test/tb.sv =====
module tb;

    localparam int unsigned WordW = talu_pkg::WordW;
    localparam int unsigned OpW   = talu_pkg::OpW;
    localparam int unsigned AmtW  = talu_pkg::AmtW;
    localparam int unsigned ShW   = talu_pkg::ShW;

    // one result word as the alu reports it
    typedef struct packed {
        logic [WordW-1:0] value;
        logic             write_back;
        logic             n;
        logic             z;
        logic             c;
        logic             v;
    } alu_word_t;

    // expected alu words and their comparison against the outputs
    class alu_scoreboard;
        alu_word_t expected_words[$];
        int        failures = 0;

        function alu_word_t compute_alu(logic [OpW-1:0] op, logic [WordW-1:0] a,
                                        logic [WordW-1:0] b, logic c_in, logic v_in);
            alu_word_t        w;
            logic [AmtW-1:0]  amt;
            logic [ShW-1:0]   rot;
            logic [WordW:0]   sum;
            logic [WordW-1:0] first;
            logic [WordW-1:0] addend;
            logic [63:0]      product;
            logic             carry_in;
            logic             use_adder;
            w.value = a;
            w.write_back = 1'b1;
            w.c = c_in;
            w.v = v_in;
            amt = b[AmtW-1:0];
            rot = amt[ShW-1:0];
            use_adder = 1'b0;
            first = a;
            addend = b;
            carry_in = c_in;
            case (op)
                talu_pkg::OP_AND: w.value = a & b;
                talu_pkg::OP_EOR: w.value = a ^ b;
                talu_pkg::OP_LSL:
                    if (amt != 0)
                    begin
                        if (amt < WordW)
                        begin
                            w.c = a[WordW - amt];
                            w.value = a << amt;
                        end
                        else
                        begin
                            w.c = (amt == WordW) ? a[0] : 1'b0;
                            w.value = '0;
                        end
                    end
                talu_pkg::OP_LSR:
                    if (amt != 0)
                    begin
                        if (amt < WordW)
                        begin
                            w.c = a[amt - 1];
                            w.value = a >> amt;
                        end
                        else
                        begin
                            w.c = (amt == WordW) ? a[WordW-1] : 1'b0;
                            w.value = '0;
                        end
                    end
                talu_pkg::OP_ASR:
                    if (amt != 0)
                    begin
                        if (amt < WordW)
                        begin
                            w.c = a[amt - 1];
                            w.value = $signed(a) >>> amt;
                        end
                        else
                        begin
                            w.c = a[WordW-1];
                            w.value = {WordW{a[WordW-1]}};
                        end
                    end
                talu_pkg::OP_ROR:
                    if (amt != 0)
                    begin
                        if (rot == 0)
                            w.c = a[WordW-1];
                        else
                        begin
                            w.c = a[rot - 1];
                            w.value = (a >> rot) | (a << (WordW - rot));
                        end
                    end
                talu_pkg::OP_ADC: use_adder = 1'b1;
                talu_pkg::OP_SBC:
                begin
                    use_adder = 1'b1;
                    addend = ~b;
                end
                talu_pkg::OP_TST:
                begin
                    w.value = a & b;
                    w.write_back = 1'b0;
                end
                talu_pkg::OP_NEG:
                begin
                    use_adder = 1'b1;
                    first = '0;
                    addend = ~b;
                    carry_in = 1'b1;
                end
                talu_pkg::OP_CMP:
                begin
                    use_adder = 1'b1;
                    addend = ~b;
                    carry_in = 1'b1;
                    w.write_back = 1'b0;
                end
                talu_pkg::OP_CMN:
                begin
                    use_adder = 1'b1;
                    carry_in = 1'b0;
                    w.write_back = 1'b0;
                end
                talu_pkg::OP_ORR: w.value = a | b;
                talu_pkg::OP_MUL:
                begin
                    product = {32'd0, a} * {32'd0, b};
                    w.value = product[WordW-1:0];
                end
                talu_pkg::OP_BIC: w.value = a & ~b;
                default: w.value = ~b;
            endcase
            // shared adder for add, subtract, negate and compares
            if (use_adder)
            begin
                sum = {1'b0, first} + {1'b0, addend} + (WordW+1)'(carry_in);
                w.value = sum[WordW-1:0];
                w.c = sum[WordW];
                w.v = ~(first[WordW-1] ^ addend[WordW-1])
                      & (first[WordW-1] ^ w.value[WordW-1]);
            end
            w.n = w.value[WordW-1];
            w.z = (w.value == 0);
            return w;
        endfunction

        function void note_word(logic [OpW-1:0] op, logic [WordW-1:0] a,
                                logic [WordW-1:0] b, logic c_in, logic v_in);
            expected_words.push_back(compute_alu(op, a, b, c_in, v_in));
        endfunction

        function void report_field(string field, logic [WordW-1:0] exp_val,
                                   logic [WordW-1:0] got_val, ref bit bad);
            if (exp_val !== got_val)
            begin
                bad = 1'b1;
                if (failures < 10)
                    $display("mismatch %s: expected %h, got %h", field, exp_val, got_val);
            end
        endfunction

        function void check_word(alu_word_t got);
            alu_word_t exp_w;
            bit        bad;
            if (expected_words.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected word: value %h", got.value);
                failures++;
                return;
            end
            exp_w = expected_words.pop_front();
            bad = 1'b0;
            report_field("value", exp_w.value, got.value, bad);
            report_field("write_back", WordW'(exp_w.write_back), WordW'(got.write_back), bad);
            report_field("n", WordW'(exp_w.n), WordW'(got.n), bad);
            report_field("z", WordW'(exp_w.z), WordW'(got.z), bad);
            report_field("c", WordW'(exp_w.c), WordW'(got.c), bad);
            report_field("v", WordW'(exp_w.v), WordW'(got.v), bad);
            if (bad)
                failures++;
        endfunction

        function int outstanding();
            return expected_words.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [OpW-1:0]   alu_op;
    logic [WordW-1:0] dest_value;
    logic [WordW-1:0] source_value;
    logic             flag_n_in;
    logic             flag_z_in;
    logic             flag_c_in;
    logic             flag_v_in;
    logic             out_valid;
    logic             out_stall;
    logic [WordW-1:0] result_value;
    logic             write_back;
    logic             flag_n_out;
    logic             flag_z_out;
    logic             flag_c_out;
    logic             flag_v_out;

    alu_scoreboard sb = new();
    bit            tx_idle_on = 1'b1;
    bit            rx_idle_on = 1'b1;
    int            rx_hold_cycles = 0;

    thumb_alu_operation_unit_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .alu_op       (alu_op),
        .dest_value   (dest_value),
        .source_value (source_value),
        .flag_n_in    (flag_n_in),
        .flag_z_in    (flag_z_in),
        .flag_c_in    (flag_c_in),
        .flag_v_in    (flag_v_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .write_back   (write_back),
        .flag_n_out   (flag_n_out),
        .flag_z_out   (flag_z_out),
        .flag_c_out   (flag_c_out),
        .flag_v_out   (flag_v_out)
    );

    always #10 clk = ~clk;

    // watch both handshakes at the clock edge
    always @(posedge clk)
    begin
        alu_word_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(alu_op, dest_value, source_value, flag_c_in, flag_v_in);
            if (out_valid && !out_stall)
            begin
                got = {result_value, write_back, flag_n_out, flag_z_out, flag_c_out, flag_v_out};
                sb.check_word(got);
            end
        end
    end

    // receiver: random stall bursts and an occasional long hold
    initial
    begin
        out_stall <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // offer one word and hold it until taken, then maybe go idle
    task automatic send_word(input logic [OpW-1:0] op, input logic [WordW-1:0] a,
                             input logic [WordW-1:0] b, input logic [3:0] nzcv);
        in_valid     <= 1'b1;
        alu_op       <= op;
        dest_value   <= a;
        source_value <= b;
        {flag_n_in, flag_z_in, flag_c_in, flag_v_in} <= nzcv;
        do @(posedge clk); while (in_stall);
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    function automatic logic [WordW-1:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            4: return 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // shift amounts lean on the boundary cases
    function automatic logic [WordW-1:0] pick_source(logic [OpW-1:0] op);
        logic [AmtW-1:0] amt;
        if (!(op inside {talu_pkg::OP_LSL, talu_pkg::OP_LSR, talu_pkg::OP_ASR,
                         talu_pkg::OP_ROR}) || $urandom_range(0, 3) == 0)
            return pick_operand();
        case ($urandom_range(0, 5))
            0: amt = AmtW'(0);
            1: amt = AmtW'(32);
            2: amt = AmtW'($urandom_range(1, 31));
            3: amt = AmtW'($urandom_range(33, 255));
            4: amt = AmtW'(32 * $urandom_range(1, 7));
            default: amt = AmtW'($urandom_range(0, 255));
        endcase
        return {(WordW-AmtW)'($urandom), amt};
    endfunction

    task automatic send_random(input int count);
        logic [OpW-1:0] op;
        repeat (count)
        begin
            op = OpW'($urandom_range(0, 15));
            send_word(op, pick_operand(), pick_source(op), 4'($urandom_range(0, 15)));
        end
    endtask

    task automatic wait_drained();
        while (sb.outstanding() != 0) @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        alu_op       <= talu_pkg::OP_AND;
        dest_value   <= '0;
        source_value <= '0;
        flag_n_in    <= 1'b0;
        flag_z_in    <= 1'b0;
        flag_c_in    <= 1'b0;
        flag_v_in    <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words: field extremes, every operation, shift corner cases
        send_word(talu_pkg::OP_AND, 32'hffff_ffff, 32'hffff_ffff, 4'b0000);
        send_word(talu_pkg::OP_EOR, 32'hffff_ffff, 32'h0000_0000, 4'b1111);
        send_word(talu_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0000, 4'b0010);
        send_word(talu_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0001, 4'b0000);
        send_word(talu_pkg::OP_LSL, 32'h8000_0001, 32'h0000_0020, 4'b0000);
        send_word(talu_pkg::OP_LSL, 32'hffff_ffff, 32'h0000_0021, 4'b0011);
        send_word(talu_pkg::OP_LSR, 32'h8000_0001, 32'h0000_0020, 4'b0000);
        send_word(talu_pkg::OP_LSR, 32'hffff_ffff, 32'hffff_ffff, 4'b0010);
        send_word(talu_pkg::OP_ASR, 32'h8000_0000, 32'h0000_001f, 4'b0000);
        send_word(talu_pkg::OP_ASR, 32'h8000_0000, 32'h0000_0028, 4'b0000);
        send_word(talu_pkg::OP_ADC, 32'h7fff_ffff, 32'h0000_0000, 4'b0010);
        send_word(talu_pkg::OP_ADC, 32'hffff_ffff, 32'hffff_ffff, 4'b0010);
        send_word(talu_pkg::OP_SBC, 32'h0000_0000, 32'h0000_0000, 4'b0001);
        send_word(talu_pkg::OP_ROR, 32'h8000_0001, 32'h0000_0040, 4'b0000);
        send_word(talu_pkg::OP_ROR, 32'h8000_0001, 32'h0000_0021, 4'b0000);
        send_word(talu_pkg::OP_TST, 32'h0000_0000, 32'hffff_ffff, 4'b1000);
        send_word(talu_pkg::OP_NEG, 32'h1234_5678, 32'h0000_0000, 4'b0000);
        send_word(talu_pkg::OP_NEG, 32'hffff_ffff, 32'h8000_0000, 4'b0000);
        send_word(talu_pkg::OP_CMP, 32'h8000_0000, 32'h0000_0001, 4'b0000);
        send_word(talu_pkg::OP_CMN, 32'hffff_ffff, 32'h0000_0001, 4'b0000);
        send_word(talu_pkg::OP_ORR, 32'h0000_0000, 32'h0000_0000, 4'b1111);
        send_word(talu_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 4'b0011);
        send_word(talu_pkg::OP_BIC, 32'hffff_ffff, 32'h0f0f_0f0f, 4'b0100);
        send_word(talu_pkg::OP_MVN, 32'h0000_0000, 32'h0000_0000, 4'b0000);
        send_word(talu_pkg::OP_ROR, 32'h1234_5678, 32'hffff_ff00, 4'b1111);

        send_random(300);

        // long receiver hold while words keep coming, then let it drain
        rx_hold_cycles = 80;
        tx_idle_on = 1'b0;
        send_random(40);
        tx_idle_on = 1'b1;
        in_valid <= 1'b0;
        wait_drained();

        send_random(300);

        // closing stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        send_random(160);
        in_valid <= 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.outstanding() == 0)
            $display("** thumb_alu_operation_unit_core: PASSED **");
        else
            $display("** thumb_alu_operation_unit_core: FAILED **");
        $finish;
    end

    // hang guard
    initial
    begin
        #20_000_000;
        $display("** thumb_alu_operation_unit_core: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/talu_pkg.sv
hw/rtl/talu_shifter.sv
hw/rtl/talu_exec.sv
hw/rtl/thumb_alu_operation_unit_core.sv
test/tb.sv
